// ===== design/trsa_pkg.sv =====
// ----------------------------------------------------------------------------
// trsa_pkg
// Shared types and constants of the tick rate sync adjuster.
// ----------------------------------------------------------------------------
package trsa_pkg;

  localparam int unsigned WORD_W      = 32;
  localparam int unsigned MUL_DIGIT_W = 2;
  localparam int unsigned MUL_STEPS   = WORD_W / MUL_DIGIT_W;
  localparam int unsigned DIV_STEPS   = WORD_W;

  localparam logic [WORD_W-1:0] PERIOD_FLOOR   = 32'd25;
  localparam logic [WORD_W-1:0] PERIOD_DEFAULT = 32'd50;
  localparam logic [WORD_W-1:0] PERIOD_SLOW    = 32'd100;

  typedef enum logic [1:0] {
    FUNC_TICK       = 2'd0,
    FUNC_SYNC       = 2'd1,
    FUNC_READ_CLEAR = 2'd2,
    FUNC_SET_PERIOD = 2'd3
  } func_e;

  typedef struct packed {
    logic [1:0]        func;
    logic [WORD_W-1:0] value;
  } in_t;

  typedef struct packed {
    logic [WORD_W-1:0] beat_count;
    logic [WORD_W-1:0] period_ms;
    logic [WORD_W-1:0] refresh_count;
    logic              synced;
  } out_t;

endpackage

// ===== design/trsa_mul.sv =====
// ----------------------------------------------------------------------------
// trsa_mul
// Serial radix-4 shift-add multiplier, low word of the product only.
// ----------------------------------------------------------------------------
module trsa_mul (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [trsa_pkg::WORD_W-1:0]   mcand_i,
  input  logic [trsa_pkg::WORD_W-1:0]   mplier_i,
  output logic                          done_o,
  output logic [trsa_pkg::WORD_W-1:0]   product_o
);
  import trsa_pkg::*;

  localparam int unsigned CNT_W = $clog2(MUL_STEPS);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MUL_STEPS - 1);

  logic [WORD_W-1:0] m1_q, m3_q, mplier_q, acc_q;
  logic [WORD_W-1:0] pp;
  logic [CNT_W-1:0]  cnt_q;
  logic              run_q, done_q;

  // partial product for the current two-bit digit
  always_comb begin
    case (mplier_q[MUL_DIGIT_W-1:0])
      2'd0:    pp = '0;
      2'd1:    pp = m1_q;
      2'd2:    pp = {m1_q[WORD_W-2:0], 1'b0};
      default: pp = m3_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= '0;
      end else if (run_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_LAST) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      m1_q     <= mcand_i;
      m3_q     <= mcand_i + {mcand_i[WORD_W-2:0], 1'b0};
      mplier_q <= mplier_i;
      acc_q    <= '0;
    end else if (run_q) begin
      acc_q    <= acc_q + pp;
      m1_q     <= m1_q << MUL_DIGIT_W;
      m3_q     <= m3_q << MUL_DIGIT_W;
      mplier_q <= mplier_q >> MUL_DIGIT_W;
    end
  end

  assign done_o    = done_q;
  assign product_o = acc_q;

endmodule

// ===== design/trsa_div.sv =====
// ----------------------------------------------------------------------------
// trsa_div
// Serial restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module trsa_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [trsa_pkg::WORD_W-1:0]   dividend_i,
  input  logic [trsa_pkg::WORD_W-1:0]   divisor_i,
  output logic                          done_o,
  output logic [trsa_pkg::WORD_W-1:0]   quotient_o
);
  import trsa_pkg::*;

  localparam int unsigned CNT_W = $clog2(DIV_STEPS);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIV_STEPS - 1);

  logic [WORD_W-1:0] rem_q, quo_q, dvsr_q;
  logic [WORD_W:0]   shifted, trial;
  logic [CNT_W-1:0]  cnt_q;
  logic              run_q, done_q;

  assign shifted = {rem_q, quo_q[WORD_W-1]};
  assign trial   = shifted - {1'b0, dvsr_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= '0;
      end else if (run_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_LAST) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= '0;
      quo_q  <= dividend_i;
      dvsr_q <= divisor_i;
    end else if (run_q) begin
      // keep the trial remainder only when it did not go negative
      if (!trial[WORD_W]) begin
        rem_q <= trial[WORD_W-1:0];
        quo_q <= {quo_q[WORD_W-2:0], 1'b1};
      end else begin
        rem_q <= shifted[WORD_W-1:0];
        quo_q <= {quo_q[WORD_W-2:0], 1'b0};
      end
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

// ===== design/tick_rate_sync_adjuster_top.sv =====
// ----------------------------------------------------------------------------
// tick_rate_sync_adjuster_top
// Local tick counter whose period is retuned to follow a remote tick count.
// ----------------------------------------------------------------------------
// One item is worked on at a time. Tick, read-and-clear, set-period and the
// syncs that need no division pass from execution straight to emit. A sync
// that retunes the period runs the radix-4 multiplier and then the restoring
// divider; a wrapped zero product skips the divider. A finished result waits
// in the output register while the next item is taken.
module tick_rate_sync_adjuster_top (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  trsa_pkg::in_t     in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output trsa_pkg::out_t    out_data_o
);
  import trsa_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_MUL,
    ST_DIV,
    ST_EMIT
  } state_e;

  state_e            state_q, state_d;
  logic [1:0]        func_q, func_d;
  logic [WORD_W-1:0] value_q, value_d;
  logic              synced_q, synced_d;
  logic [WORD_W-1:0] local_q, local_d;
  logic [WORD_W-1:0] beats_last_q, beats_last_d;
  logic [WORD_W-1:0] remote_last_q, remote_last_d;
  logic [WORD_W-1:0] period_q, period_d;
  logic [WORD_W-1:0] refresh_q, refresh_d;
  logic [WORD_W-1:0] shown_q, shown_d;
  logic [WORD_W-1:0] needed_q, needed_d;
  logic              out_valid_q, out_valid_d;
  out_t              out_q, out_d;

  logic [WORD_W-1:0] predicted;
  logic              mul_start, mul_done, div_start, div_done;
  logic [WORD_W-1:0] product, quotient;
  logic              in_xfer;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign predicted  = (value_q - remote_last_q) + value_q;

  trsa_mul u_mul (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (mul_start),
    .mcand_i   (period_q),
    .mplier_i  (local_q - beats_last_q),
    .done_o    (mul_done),
    .product_o (product)
  );

  trsa_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (product),
    .divisor_i  (needed_q),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  always_comb begin
    state_d       = state_q;
    func_d        = func_q;
    value_d       = value_q;
    synced_d      = synced_q;
    local_d       = local_q;
    beats_last_d  = beats_last_q;
    remote_last_d = remote_last_q;
    period_d      = period_q;
    refresh_d     = refresh_q;
    shown_d       = shown_q;
    needed_d      = needed_q;
    out_d         = out_q;
    out_valid_d   = out_valid_q && out_stall_i;
    mul_start     = 1'b0;
    div_start     = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          func_d  = in_data_i.func;
          value_d = in_data_i.value;
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_d = ST_EMIT;
        shown_d = refresh_q;
        case (func_e'(func_q))
          FUNC_TICK: begin
            refresh_d = refresh_q + 1'b1;
            local_d   = local_q + 1'b1;
            shown_d   = refresh_q + 1'b1;
          end
          FUNC_SYNC: begin
            if (!synced_q) begin
              // first sync loads the local, last-beat and last-remote counts and the default period
              synced_d      = 1'b1;
              local_d       = value_q;
              beats_last_d  = value_q;
              remote_last_d = value_q;
              period_d      = PERIOD_DEFAULT;
            end else if (predicted > local_q) begin
              needed_d  = predicted - local_q;
              mul_start = 1'b1;
              state_d   = ST_MUL;
            end else if (predicted < local_q) begin
              beats_last_d  = local_q;
              remote_last_d = value_q;
              period_d      = PERIOD_SLOW;
            end
          end
          FUNC_READ_CLEAR: begin
            refresh_d = '0;
          end
          FUNC_SET_PERIOD: begin
            period_d = value_q;
          end
          default: begin
            state_d = ST_EMIT;
          end
        endcase
      end
      ST_MUL: begin
        if (mul_done) begin
          if (product == '0) begin
            period_d      = PERIOD_DEFAULT;
            beats_last_d  = local_q;
            remote_last_d = value_q;
            state_d       = ST_EMIT;
          end else begin
            div_start = 1'b1;
            state_d   = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        if (div_done) begin
          period_d      = (quotient < PERIOD_FLOOR) ? PERIOD_FLOOR : quotient;
          beats_last_d  = local_q;
          remote_last_d = value_q;
          state_d       = ST_EMIT;
        end
      end
      ST_EMIT: begin
        // hold until the output register is free
        if (!out_valid_q || !out_stall_i) begin
          out_d.beat_count    = local_q;
          out_d.period_ms     = period_q;
          out_d.refresh_count = shown_q;
          out_d.synced        = synced_q;
          out_valid_d         = 1'b1;
          state_d             = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      synced_q      <= 1'b0;
      local_q       <= '0;
      beats_last_q  <= '0;
      remote_last_q <= '0;
      period_q      <= PERIOD_DEFAULT;
      refresh_q     <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q       <= state_d;
      synced_q      <= synced_d;
      local_q       <= local_d;
      beats_last_q  <= beats_last_d;
      remote_last_q <= remote_last_d;
      period_q      <= period_d;
      refresh_q     <= refresh_d;
      out_valid_q   <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    func_q   <= func_d;
    value_q  <= value_d;
    shown_q  <= shown_d;
    needed_q <= needed_d;
    out_q    <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_mul_done_in_mul: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_done |-> state_q == ST_MUL)
    else $error("multiplier finished outside the multiply step");

  a_div_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == ST_DIV)
    else $error("divider finished outside the divide step");

  a_synced_sticks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$fell(synced_q))
    else $error("synced flag dropped without reset");

  a_xfer_to_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> state_q == ST_EXEC)
    else $error("accepted transfer not taken to execution");

  a_div_needs_product: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> product != '0 && needed_q != '0)
    else $error("divide started with a zero operand");

endmodule
